/* hdl/bde_pkg.sv */
package bde_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DEGREE_DEF     = 2;
  localparam int COORD_W        = 16;
  localparam int KNOT_W         = 16;
  localparam int CNT_W          = 7;
  localparam int FRAC_W         = 16;
  // Q.16 point width: 16-bit integer part plus 16 fraction bits, one guard bit
  localparam int PT_W           = COORD_W + FRAC_W + 1;
  localparam int DIV_W          = FRAC_W + 1;

  typedef enum logic [1:0] {
    REQ_WR_POINT = 2'd0,
    REQ_WR_KNOT  = 2'd1,
    REQ_EVAL     = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_BL_RD,
    ST_BL_KNOT,
    ST_BL_DIV,
    ST_BL_MUL,
    ST_BL_SUM,
    ST_DONE
  } state_t;

endpackage

/* hdl/bspline_de_boor_evaluator.sv */
// Channel   Ports                                       Transfer
// input     in_req_type in_index in_point_x/_y          start high, busy low
//           in_param_value
// result    out_curve_x out_curve_y out_status          out_valid, one cycle
// config    cfg_we cfg_point_count                      cfg_we high
//
// An evaluate tests one span per SRCH_RD and two SRCH_CMP passes, up to
// point_count-DEGREE spans, loads DEGREE+1 points via LOAD_RD and LOAD_WR,
// then runs DEGREE*(DEGREE+1)/2 blends: BL_RD, BL_KNOT, BL_DIV (a 33-step
// restoring divider), BL_MUL, BL_SUM. The result comes in the first cycle with
// busy low. Reset is synchronous and clears only the controller and the point
// count. The receiver cannot stall; out_valid is a single-cycle strobe.
module bspline_de_boor_evaluator
  import bde_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int DEGREE     = DEGREE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic [CNT_W-1:0]          in_index,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [KNOT_W-1:0]         in_param_value,
  input  logic                      cfg_we,
  input  logic [CNT_W-1:0]          cfg_point_count,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y,
  output logic                      out_status
);

  localparam int KNOT_DEPTH = MAX_POINTS + DEGREE + 1;
  localparam int PA_W = $clog2(MAX_POINTS);
  localparam int KA_W = $clog2(KNOT_DEPTH);
  localparam int IW   = $clog2(KNOT_DEPTH + 1);
  localparam int DA_W = $clog2(DEGREE + 1);
  localparam int DC_W = $clog2(DIV_W + FRAC_W + 2);
  localparam int PRD_W = PT_W + DIV_W + 1;

  // storage
  logic [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
  logic [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
  logic [KNOT_W-1:0]  knot_mem   [KNOT_DEPTH];
  logic signed [PT_W-1:0] dx_mem [DEGREE+1];
  logic signed [PT_W-1:0] dy_mem [DEGREE+1];

  logic [CNT_W-1:0] point_count_r;
  state_t state_r, state_nxt;

  logic [KNOT_W-1:0] t_r;
  logic [IW-1:0]     i_r, n_eff;
  logic [IW-1:0]     span_r;
  logic [DA_W-1:0]   r_r, j_r;
  logic              second_r;   // second knot read of a pair

  // memory ports
  logic [KA_W-1:0]    k_addr;
  logic [KNOT_W-1:0]  k_rd_r;
  logic [PA_W-1:0]    p_addr;
  logic [COORD_W-1:0] px_rd_r, py_rd_r;
  logic [DA_W-1:0]    d_addr;
  logic signed [PT_W-1:0] dxa_r, dya_r, dxb_r, dyb_r;

  logic [KNOT_W-1:0] klo_r;
  logic              wr_pt, wr_kn, accept;

  // divider
  logic [DIV_W+FRAC_W-1:0] quo_r;
  logic [DIV_W:0]          rem_r;
  logic [DIV_W-1:0]        den_r;
  logic [DC_W-1:0]         dcnt_r;
  logic                    q_neg_r, den_zero_r;
  logic [DIV_W-1:0]        alpha;
  logic signed [PRD_W-1:0] px_r, py_r, qx_r, qy_r;
  logic signed [PRD_W-1:0] sx, sy;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign wr_pt  = accept && (in_req_type == REQ_WR_POINT) && (32'(in_index) < MAX_POINTS);
  assign wr_kn  = accept && (in_req_type == REQ_WR_KNOT) && (32'(in_index) < KNOT_DEPTH);
  assign n_eff  = (32'(point_count_r) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(point_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) point_count_r <= CNT_W'(3);
    else if (cfg_we) point_count_r <= cfg_point_count;
  end

  // knot address: search reads i and i+1; blend reads l then l+DEGREE+1-j
  always_comb begin
    k_addr = KA_W'(i_r);
    if (state_r == ST_SRCH_CMP)
      k_addr = KA_W'(i_r + IW'(1));
    else if (state_r == ST_BL_RD)
      k_addr = KA_W'(span_r - IW'(DEGREE) + IW'(r_r));
    else if (state_r == ST_BL_KNOT)
      k_addr = KA_W'(span_r - IW'(DEGREE) + IW'(r_r) + IW'(DEGREE + 1) - IW'(j_r));
    if (wr_kn) k_addr = KA_W'(in_index);
  end

  always_ff @(posedge clk) begin
    if (wr_kn) knot_mem[k_addr] <= in_param_value;
    k_rd_r <= knot_mem[k_addr];
  end

  assign p_addr = wr_pt ? PA_W'(in_index) : PA_W'(span_r - IW'(DEGREE) + IW'(r_r));
  always_ff @(posedge clk) begin
    if (wr_pt) begin
      ctrl_x_mem[p_addr] <= in_point_x;
      ctrl_y_mem[p_addr] <= in_point_y;
    end
    px_rd_r <= ctrl_x_mem[p_addr];
    py_rd_r <= ctrl_y_mem[p_addr];
  end

  // working points: read r-1 and r, write r after the blend
  assign d_addr = r_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD_WR) begin
      dx_mem[d_addr] <= {{(PT_W-COORD_W-FRAC_W){px_rd_r[COORD_W-1]}}, px_rd_r, FRAC_W'(0)};
      dy_mem[d_addr] <= {{(PT_W-COORD_W-FRAC_W){py_rd_r[COORD_W-1]}}, py_rd_r, FRAC_W'(0)};
    end else if (state_r == ST_BL_SUM) begin
      dx_mem[d_addr] <= PT_W'(sx >>> FRAC_W) + PT_W'((sx < 0) && (sx[FRAC_W-1:0] != '0));
      dy_mem[d_addr] <= PT_W'(sy >>> FRAC_W) + PT_W'((sy < 0) && (sy[FRAC_W-1:0] != '0));
    end
    if (state_r == ST_BL_RD) begin
      dxa_r <= dx_mem[d_addr - DA_W'(1)];
      dya_r <= dy_mem[d_addr - DA_W'(1)];
      dxb_r <= dx_mem[d_addr];
      dyb_r <= dy_mem[d_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (accept && in_req_type == REQ_EVAL) state_nxt = ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = (i_r < n_eff) ? ST_SRCH_CMP : ST_DONE;
      ST_SRCH_CMP:
        if (second_r) begin
          if (klo_r <= t_r && t_r < k_rd_r) state_nxt = ST_LOAD_RD;
          else state_nxt = ST_SRCH_RD;
        end else state_nxt = ST_SRCH_CMP;
      ST_LOAD_RD:  state_nxt = ST_LOAD_WR;
      ST_LOAD_WR:  state_nxt = (r_r == DA_W'(DEGREE)) ? ST_BL_RD : ST_LOAD_RD;
      ST_BL_RD:    state_nxt = ST_BL_KNOT;
      ST_BL_KNOT:  state_nxt = ST_BL_DIV;
      ST_BL_DIV:   state_nxt = (dcnt_r == '0) ? ST_BL_MUL : ST_BL_DIV;
      ST_BL_MUL:   state_nxt = ST_BL_SUM;
      ST_BL_SUM:
        if (r_r == j_r) state_nxt = (j_r == DA_W'(DEGREE)) ? ST_DONE : ST_BL_RD;
        else state_nxt = ST_BL_RD;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  logic signed [DIV_W+1:0] num_s, den_s;
  assign num_s = $signed({3'b0, t_r}) - $signed({3'b0, klo_r});
  assign den_s = $signed({3'b0, k_rd_r}) - $signed({3'b0, klo_r});
  logic [DIV_W:0] rem_try;
  assign rem_try = {rem_r[DIV_W-1:0], quo_r[DIV_W+FRAC_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_DONE);
      unique case (state_r)
        ST_IDLE: begin
          t_r <= in_param_value;
          i_r <= IW'(DEGREE);
          second_r <= 1'b0;
          out_status <= 1'b1;
        end
        ST_SRCH_RD: second_r <= 1'b0;
        ST_SRCH_CMP:
          if (!second_r) second_r <= 1'b1;
          else begin
            second_r <= 1'b0;
            if (klo_r <= t_r && t_r < k_rd_r) begin
              span_r <= i_r;
              r_r <= '0;
              out_status <= 1'b0;
            end else i_r <= i_r + IW'(1);
          end
        ST_LOAD_WR: begin
          if (r_r == DA_W'(DEGREE)) begin
            r_r <= DA_W'(DEGREE);
            j_r <= DA_W'(1);
          end else r_r <= r_r + DA_W'(1);
        end
        ST_BL_KNOT: dcnt_r <= DC_W'(DIV_W + FRAC_W + 1);
        ST_BL_DIV: begin
          if (dcnt_r == DC_W'(DIV_W + FRAC_W + 1)) begin
            // first cycle: k_rd_r holds the upper knot
            q_neg_r <= (num_s < 0) != (den_s < 0);
            den_zero_r <= (den_s == 0);
            den_r <= (den_s < 0) ? DIV_W'(-den_s) : DIV_W'(den_s);
            quo_r <= {(num_s < 0) ? DIV_W'(-num_s) : DIV_W'(num_s), FRAC_W'(0)};
            rem_r <= '0;
            dcnt_r <= dcnt_r - DC_W'(1);
          end else if (dcnt_r != '0) begin
            if (rem_try >= {1'b0, den_r}) begin
              rem_r <= rem_try - {1'b0, den_r};
              quo_r <= {quo_r[DIV_W+FRAC_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_try;
              quo_r <= {quo_r[DIV_W+FRAC_W-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - DC_W'(1);
          end
        end
        ST_BL_MUL: begin
          px_r <= PRD_W'(dxa_r) * PRD_W'($signed({1'b0, DIV_W'(1 << FRAC_W) - alpha}));
          py_r <= PRD_W'(dya_r) * PRD_W'($signed({1'b0, DIV_W'(1 << FRAC_W) - alpha}));
          qx_r <= PRD_W'(dxb_r) * PRD_W'($signed({1'b0, alpha}));
          qy_r <= PRD_W'(dyb_r) * PRD_W'($signed({1'b0, alpha}));
        end
        ST_BL_SUM:
          if (r_r == j_r) begin
            r_r <= DA_W'(DEGREE);
            j_r <= j_r + DA_W'(1);
          end else r_r <= r_r - DA_W'(1);
        default: ;
      endcase
    end
  end

  // low knot captured in the cycle after its read is issued
  always_ff @(posedge clk) begin
    if ((state_r == ST_SRCH_CMP && !second_r) || state_r == ST_BL_KNOT) klo_r <= k_rd_r;
  end

  // clamp quotient to [0, 1.0]; negative or zero-denominator gives 0
  always_comb begin
    alpha = '0;
    if (!den_zero_r && (q_neg_r == 1'b0) && (quo_r != '0)) begin
      if (quo_r > (DIV_W+FRAC_W)'(1 << FRAC_W)) alpha = DIV_W'(1 << FRAC_W);
      else alpha = DIV_W'(quo_r);
    end
  end

  assign sx = px_r + qx_r;
  assign sy = py_r + qy_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      if (out_status) begin
        out_curve_x <= '0;
        out_curve_y <= '0;
      end else begin
        out_curve_x <= COORD_W'((dx_mem[DEGREE] >>> FRAC_W) +
          PT_W'((dx_mem[DEGREE] < 0) && (dx_mem[DEGREE][FRAC_W-1:0] != '0)));
        out_curve_y <= COORD_W'((dy_mem[DEGREE] >>> FRAC_W) +
          PT_W'((dy_mem[DEGREE] < 0) && (dy_mem[DEGREE][FRAC_W-1:0] != '0)));
      end
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept) else $error("accept while busy");
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without evaluate");
`endif

endmodule
